/* design/dpru_pkg.sv */
`default_nettype none

package dpru_pkg;

  localparam int MAX_N_DEFAULT = 16;

  localparam int HEIGHT_W = 5;
  localparam int INDEX_W  = 32;
  localparam int VALUE_W  = 26;
  localparam int CFG_W    = 5;
  localparam int COUNT_W  = 32;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  // register index, taken from paddr above the byte offset
  localparam logic [APB_AW-3:0] REG_HALF_LENGTH = '0;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_UNRANK = 1'b1;

  typedef enum logic [1:0] {
    RK_RANK   = 2'd0,
    RK_HEIGHT = 2'd1,
    RK_ERROR  = 2'd2
  } result_kind_t;

endpackage

`default_nettype wire

/* design/dpru_item_if.sv */
`default_nettype none

interface dpru_item_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [dpru_pkg::HEIGHT_W-1:0] height;
  logic [dpru_pkg::INDEX_W-1:0]  order_index;

  modport source (output valid, kind, height, order_index, input ready);
  modport sink (input valid, kind, height, order_index, output ready);
endinterface

`default_nettype wire

/* design/dpru_result_if.sv */
`default_nettype none

interface dpru_result_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   result_kind;
  logic [dpru_pkg::VALUE_W-1:0] value;
  logic                         last;

  modport source (output valid, result_kind, value, last, input ready);
  modport sink (input valid, result_kind, value, last, output ready);
endinterface

`default_nettype wire

/* design/dyck_path_rank_unrank.sv */
`default_nettype none

// Dyck path ranker and unranker. A one-port-read table memory holds, for every point
// (u,d) with d <= u <= n, the number of paths to (n,n); it is rebuilt after reset and
// after each write of half_length, and no beat is accepted while it is rebuilt. A height
// sample takes one table read, and a whole rank takes 2n+1 samples. An unrank request
// passes S_UNR_RD0 and S_UNR_CHK to its first height and then S_UNR_RD and S_UNR_STEP
// for each further height (one table read per step), or ends after S_UNR_CHK when the
// index is out of range. Result beats wait in a single output register.
module dyck_path_rank_unrank #(
  parameter int MAX_N = dpru_pkg::MAX_N_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dpru_pkg::APB_AW-1:0] paddr,
  input  wire logic [dpru_pkg::APB_DW-1:0] pwdata,
  output logic      [dpru_pkg::APB_DW-1:0] prdata,
  output logic                             pready,
  dpru_item_if.sink                        items,
  dpru_result_if.source                    results
);
  import dpru_pkg::*;

  localparam int TDIM  = MAX_N + 1;
  localparam int DEPTH = TDIM * TDIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_N + 2);
  localparam int PW    = $clog2(2 * MAX_N + 1);

  typedef enum logic [3:0] {
    S_FILL_INIT,
    S_FILL_RD,
    S_FILL_WR,
    S_IDLE,
    S_RANK,
    S_UNR_RD0,
    S_UNR_CHK,
    S_UNR_RD,
    S_UNR_STEP
  } state_t;

  function automatic logic [AW-1:0] tab_addr(input logic [CW-1:0] u, input logic [CW-1:0] d);
    tab_addr = AW'(u) * AW'(TDIM) + AW'(d);
  endfunction

  state_t state;

  logic [CW-1:0] half_length;

  // table memory
  logic [COUNT_W-1:0] table_mem [DEPTH];
  logic [COUNT_W-1:0] rdata;
  logic [AW-1:0]      rd_addr;
  logic               mem_we;
  logic [AW-1:0]      wr_addr;
  logic [COUNT_W-1:0] wr_data;

  // fill sweep
  logic [CW-1:0]      fill_u;
  logic [CW-1:0]      fill_d;
  logic [COUNT_W-1:0] fill_prev;
  logic [COUNT_W-1:0] fill_sum;

  // rank state
  logic [PW-1:0]       sample_position;
  logic [CW-1:0]       ups_taken;
  logic [CW-1:0]       downs_taken;
  logic [HEIGHT_W-1:0] previous_height;
  logic [COUNT_W-1:0]  rank_sum;
  logic                path_invalid;

  // latched input beat
  logic [HEIGHT_W-1:0] in_height;
  logic [INDEX_W-1:0]  in_order;

  // unrank walk
  logic [COUNT_W-1:0] unr_rem;
  logic [CW-1:0]      unr_u;
  logic [CW-1:0]      unr_d;
  logic [CW-1:0]      unr_ht;
  logic [PW-1:0]      unr_step;

  // output register
  logic               out_valid;
  result_kind_t       out_kind;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;
  logic               out_free;

  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_raw;
  logic [CW-1:0]      cfg_n;
  logic [PW-1:0]      two_n;

  logic [CW:0]        rank_d1;
  logic               rank_alt_ok;
  logic [CW:0]        unr_d1;
  logic               unr_alt_ok;
  logic [COUNT_W-1:0] unr_alt;

  logic               r_inv;
  logic [CW-1:0]      r_ups;
  logic [CW-1:0]      r_downs;
  logic [COUNT_W-1:0] r_sum;
  logic               r_done;
  logic               r_good;

  logic               u_take_up;
  logic [CW-1:0]      u_ht_next;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_HALF_LENGTH);
  assign cfg_raw = pwdata[CFG_W-1:0];

  always_comb begin
    if (cfg_raw == '0) begin
      cfg_n = CW'(1);
    end else if (cfg_raw > CFG_W'(MAX_N)) begin
      cfg_n = CW'(MAX_N);
    end else begin
      cfg_n = CW'(cfg_raw);
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[APB_AW-1:2] == REG_HALF_LENGTH) begin
      prdata = APB_DW'(half_length);
    end
  end

  assign two_n    = PW'({half_length, 1'b0});
  assign out_free = !out_valid || results.ready;

  assign items.ready         = (state == S_IDLE);
  assign results.valid       = out_valid;
  assign results.result_kind = out_kind;
  assign results.value       = out_value;
  assign results.last        = out_last;

  // alternative down branch from the current point, zero where d would pass u
  assign rank_d1     = {1'b0, downs_taken} + 1'b1;
  assign rank_alt_ok = (rank_d1 <= {1'b0, ups_taken});
  assign unr_d1      = {1'b0, unr_d} + 1'b1;
  assign unr_alt_ok  = (unr_d1 <= {1'b0, unr_u});
  assign unr_alt     = unr_alt_ok ? rdata : '0;

  always_comb begin
    unique case (state)
      S_FILL_INIT, S_FILL_RD, S_FILL_WR: rd_addr = tab_addr(fill_u, CW'(fill_d + 1'b1));
      S_UNR_RD0, S_UNR_CHK:              rd_addr = '0;
      S_UNR_RD, S_UNR_STEP:              rd_addr = unr_alt_ok ? tab_addr(unr_u, unr_d1[CW-1:0]) : '0;
      S_IDLE, S_RANK:
        rd_addr = rank_alt_ok ? tab_addr(ups_taken, rank_d1[CW-1:0]) : '0;
      default:                           rd_addr = '0;
    endcase
  end

  assign fill_sum = fill_prev + (((CW+1)'(fill_d) + 1'b1 <= (CW+1)'(fill_u)) ? rdata : '0);

  always_comb begin
    mem_we  = 1'b0;
    wr_addr = tab_addr(fill_u, fill_d);
    wr_data = fill_sum;
    if (state == S_FILL_INIT) begin
      mem_we  = 1'b1;
      wr_addr = tab_addr(half_length, half_length);
      wr_data = COUNT_W'(1);
    end else if (state == S_FILL_WR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= wr_data;
    end
    rdata <= table_mem[rd_addr];
  end

  // one rank sample applied to the path state
  always_comb begin
    r_inv   = path_invalid;
    r_ups   = ups_taken;
    r_downs = downs_taken;
    r_sum   = rank_sum;
    if (sample_position == '0) begin
      if (in_height != '0) r_inv = 1'b1;
    end else if (in_height > previous_height) begin
      if (({1'b0, in_height} == {1'b0, previous_height} + 1'b1) && (ups_taken < half_length)) begin
        r_sum = rank_sum + (rank_alt_ok ? rdata : '0);
        r_ups = ups_taken + 1'b1;
      end else begin
        r_inv = 1'b1;
      end
    end else begin
      if (({1'b0, in_height} + 1'b1 == {1'b0, previous_height}) && (downs_taken < ups_taken)) begin
        r_downs = downs_taken + 1'b1;
      end else begin
        r_inv = 1'b1;
      end
    end
    r_done = (sample_position >= two_n);
    r_good = !r_inv && (r_ups == half_length) && (r_downs == half_length);
  end

  always_comb begin
    u_take_up = (unr_rem >= unr_alt) && (unr_u < half_length);
    if (u_take_up) begin
      u_ht_next = unr_ht + 1'b1;
    end else if (unr_ht != '0) begin
      u_ht_next = unr_ht - 1'b1;
    end else begin
      u_ht_next = unr_ht;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_FILL_INIT;
      half_length     <= CW'(1);
      sample_position <= '0;
      ups_taken       <= '0;
      downs_taken     <= '0;
      previous_height <= '0;
      rank_sum        <= '0;
      path_invalid    <= 1'b0;
      out_valid       <= 1'b0;
      fill_u          <= '0;
      fill_d          <= '0;
      fill_prev       <= '0;
    end else begin
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_FILL_INIT: begin
          fill_u    <= half_length;
          fill_d    <= half_length - 1'b1;
          fill_prev <= '0;
          state     <= S_FILL_RD;
        end
        S_FILL_RD: begin
          state <= S_FILL_WR;
        end
        S_FILL_WR: begin
          fill_prev <= fill_sum;
          if (fill_u == fill_d) begin
            if (fill_d == '0) begin
              state <= S_IDLE;
            end else begin
              fill_d    <= fill_d - 1'b1;
              fill_u    <= half_length;
              fill_prev <= '0;
              state     <= S_FILL_RD;
            end
          end else begin
            fill_u <= fill_u - 1'b1;
            state  <= S_FILL_RD;
          end
        end
        S_IDLE: begin
          if (items.valid) begin
            in_height <= items.height;
            in_order  <= items.order_index;
            state     <= (items.kind == KIND_UNRANK) ? S_UNR_RD0 : S_RANK;
          end
        end
        S_RANK: begin
          if (!r_done) begin
            ups_taken       <= r_ups;
            downs_taken     <= r_downs;
            rank_sum        <= r_sum;
            path_invalid    <= r_inv;
            previous_height <= in_height;
            sample_position <= sample_position + 1'b1;
            state           <= S_IDLE;
          end else if (out_free) begin
            out_valid       <= 1'b1;
            out_kind        <= r_good ? RK_RANK : RK_ERROR;
            out_value       <= r_good ? VALUE_W'(r_sum + 1'b1) : '0;
            out_last        <= 1'b1;
            sample_position <= '0;
            ups_taken       <= '0;
            downs_taken     <= '0;
            previous_height <= '0;
            rank_sum        <= '0;
            path_invalid    <= 1'b0;
            state           <= S_IDLE;
          end
        end
        S_UNR_RD0: begin
          state <= S_UNR_CHK;
        end
        S_UNR_CHK: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if ((in_order == '0) || (in_order > rdata)) begin
              out_kind  <= RK_ERROR;
              out_value <= '0;
              out_last  <= 1'b1;
              state     <= S_IDLE;
            end else begin
              out_kind  <= RK_HEIGHT;
              out_value <= '0;
              out_last  <= 1'b0;
              unr_rem   <= in_order - 1'b1;
              unr_u     <= '0;
              unr_d     <= '0;
              unr_ht    <= '0;
              unr_step  <= '0;
              state     <= S_UNR_RD;
            end
          end
        end
        S_UNR_RD: begin
          state <= S_UNR_STEP;
        end
        S_UNR_STEP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= RK_HEIGHT;
            out_value <= VALUE_W'(u_ht_next);
            out_last  <= (unr_step + 1'b1 == two_n);
            unr_ht    <= u_ht_next;
            unr_step  <= unr_step + 1'b1;
            if (u_take_up) begin
              unr_rem <= unr_rem - unr_alt;
              unr_u   <= unr_u + 1'b1;
            end else begin
              unr_d <= unr_d + 1'b1;
            end
            state <= (unr_step + 1'b1 == two_n) ? S_IDLE : S_UNR_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // a new n rebuilds the table and drops any partial path
      if (cfg_we) begin
        half_length     <= cfg_n;
        state           <= S_FILL_INIT;
        sample_position <= '0;
        ups_taken       <= '0;
        downs_taken     <= '0;
        previous_height <= '0;
        rank_sum        <= '0;
        path_invalid    <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
